FILE: hdl/pffa_pkg.sv
package pffa_pkg;

   // sizing
   localparam int MAX_PAGES = 4096;
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int COUNT_W   = $clog2(MAX_PAGES + 1);
   localparam int REG_W     = 13;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;

   // request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_BUILD = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_NO_FREE      = 2'd1,
      ST_RANGE        = 2'd2,
      ST_NOT_FREEABLE = 2'd3
   } status_type;

   // per-page state kept in the state ram
   typedef enum logic [1:0] {
      PS_FREE  = 2'd0,
      PS_ALLOC = 2'd1,
      PS_SYS   = 2'd2,
      PS_BAD   = 2'd3
   } page_state_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TOTAL_PAGES  = 3'd0,
      REG_SYSTEM_PAGES = 3'd1,
      REG_HOLE_A_START = 3'd2,
      REG_HOLE_A_END   = 3'd3,
      REG_HOLE_B_START = 3'd4,
      REG_HOLE_B_END   = 3'd5
   } reg_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear_en;
      logic accept;
      logic build_en;
      logic exec_en;
      logic finish_en;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sweep_last;
      logic slot_free;
   } dp_stat_type;

endpackage

FILE: hdl/pffa_ram.sv
module pffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pffa_ctrl.sv
module pffa_ctrl import pffa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_command,
   input  dp_stat_type         dp_stat,
   output ctrl_cmd_type        ctrl_cmd
);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_BUILD  = 5'b00100,
      S_EXEC   = 5'b01000,
      S_FINISH = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ctrl_cmd.clear_en = 1'b1;
            if (dp_stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               ctrl_cmd.accept = 1'b1;
               unique case (command_type'(req_command)) inside
                  CMD_BUILD: state_in = S_BUILD;
                  CMD_ALLOC, CMD_FREE: state_in = S_EXEC;
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_BUILD: begin
            ctrl_cmd.build_en = 1'b1;
            if (dp_stat.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_EXEC: begin
            if (dp_stat.slot_free) begin
               ctrl_cmd.exec_en = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            if (dp_stat.slot_free) begin
               ctrl_cmd.finish_en = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // at most one datapath action per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.clear_en, ctrl_cmd.accept, ctrl_cmd.build_en,
                ctrl_cmd.exec_en, ctrl_cmd.finish_en}))
      else $error("controller issued more than one datapath action");

   // a build runs until the last page and then reports
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUILD && dp_stat.sweep_last) |=> (state_ff == S_FINISH))
      else $error("build did not finish after the last page");

endmodule

FILE: hdl/pffa_dp.sv
module pffa_dp import pffa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        ctrl_cmd,
   output dp_stat_type         dp_stat,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [PAGE_W-1:0]   req_page,
   input  logic                csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]    csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PAGE_W-1:0]   rsp_page_out,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_free_count
);

   // configuration registers
   logic [REG_W-1:0] total_pages_ff;
   logic [REG_W-1:0] system_pages_ff;
   logic [REG_W-1:0] hole_a_start_ff;
   logic [REG_W-1:0] hole_a_end_ff;
   logic [REG_W-1:0] hole_b_start_ff;
   logic [REG_W-1:0] hole_b_end_ff;

   // list control
   logic [PAGE_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PAGE_W-1:0]  sweep_ff, sweep_in;
   command_type        cmd_ff;
   logic [PAGE_W-1:0]  page_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]   rsp_page_out_ff;
   status_type          rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_free_count_ff;
   logic [PAGE_W-1:0]   res_page;
   status_type          res_status;
   logic                rsp_load;

   // ram ports
   logic               state_we;
   logic [PAGE_W-1:0]  state_waddr;
   page_state_type     state_wdata;
   logic [1:0]         state_rdata;
   logic               link_we;
   logic [PAGE_W-1:0]  link_waddr;
   logic [PAGE_W-1:0]  link_wdata;
   logic [PAGE_W-1:0]  link_rdata;

   // build classification of the swept page
   logic [REG_W-1:0] sweep_ext;
   logic             sweep_bad;
   logic             sweep_sys;
   logic             sweep_last;

   assign sweep_ext  = REG_W'(sweep_ff);
   assign sweep_bad  = (sweep_ext >= total_pages_ff) ||
                       (sweep_ext >= hole_a_start_ff && sweep_ext < hole_a_end_ff) ||
                       (sweep_ext >= hole_b_start_ff && sweep_ext < hole_b_end_ff);
   assign sweep_sys  = (sweep_ext < system_pages_ff);
   assign sweep_last = (sweep_ff == PAGE_W'(MAX_PAGES - 1));

   assign rsp_load = ctrl_cmd.exec_en | ctrl_cmd.finish_en;

   assign dp_stat.sweep_last = sweep_last;
   assign dp_stat.slot_free  = ~rsp_valid_ff | rsp_ready;

   // state ram: one 2-bit state per page
   pffa_ram #(
      .WIDTH ($bits(page_state_type)),
      .DEPTH (MAX_PAGES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (state_we),
      .wr_addr (state_waddr),
      .wr_data (state_wdata),
      .rd_en   (ctrl_cmd.accept),
      .rd_addr (req_page),
      .rd_data (state_rdata)
   );

   // link ram: next entry of the free list
   pffa_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (MAX_PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (ctrl_cmd.accept),
      .rd_addr (head_ff),
      .rd_data (link_rdata)
   );

   // list update for clear, build, allocate and free
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      sweep_in    = sweep_ff;
      state_we    = 1'b0;
      state_waddr = sweep_ff;
      state_wdata = PS_FREE;
      link_we     = 1'b0;
      link_waddr  = sweep_ff;
      link_wdata  = head_ff;
      res_page    = '0;
      res_status  = ST_OK;

      if (ctrl_cmd.clear_en) begin
         state_we = 1'b1;
         sweep_in = sweep_last ? '0 : sweep_ff + 1'b1;
      end

      if (ctrl_cmd.accept && command_type'(req_command) == CMD_BUILD) begin
         head_in  = '0;
         count_in = '0;
         sweep_in = '0;
      end

      if (ctrl_cmd.build_en) begin
         state_we = 1'b1;
         sweep_in = sweep_last ? '0 : sweep_ff + 1'b1;
         if (sweep_bad) begin
            state_wdata = PS_BAD;
         end else if (sweep_sys) begin
            state_wdata = PS_SYS;
         end else begin
            link_we  = 1'b1;
            head_in  = sweep_ff;
            count_in = count_ff + 1'b1;
         end
      end

      if (ctrl_cmd.exec_en) begin
         case (cmd_ff)
            CMD_ALLOC: begin
               if (count_ff == '0) begin
                  res_status = ST_NO_FREE;
               end else begin
                  res_page    = head_ff;
                  head_in     = link_rdata;
                  count_in    = count_ff - 1'b1;
                  state_we    = 1'b1;
                  state_waddr = head_ff;
                  state_wdata = PS_ALLOC;
               end
            end
            CMD_FREE: begin
               if (REG_W'(page_ff) >= total_pages_ff) begin
                  res_status = ST_RANGE;
               end else if (page_state_type'(state_rdata) == PS_FREE ||
                            page_state_type'(state_rdata) == PS_BAD) begin
                  res_status = ST_NOT_FREEABLE;
               end else begin
                  link_we     = 1'b1;
                  link_waddr  = page_ff;
                  head_in     = page_ff;
                  count_in    = count_ff + 1'b1;
                  state_we    = 1'b1;
                  state_waddr = page_ff;
               end
            end
            default: begin
               res_status = ST_OK;
            end
         endcase
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         count_ff        <= '0;
         sweep_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         total_pages_ff  <= REG_W'(MAX_PAGES);
         system_pages_ff <= '0;
         hole_a_start_ff <= '0;
         hole_a_end_ff   <= '0;
         hole_b_start_ff <= '0;
         hole_b_end_ff   <= '0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (reg_index_type'(csr_index))
               REG_TOTAL_PAGES:  total_pages_ff  <= csr_data;
               REG_SYSTEM_PAGES: system_pages_ff <= csr_data;
               REG_HOLE_A_START: hole_a_start_ff <= csr_data;
               REG_HOLE_A_END:   hole_a_end_ff   <= csr_data;
               REG_HOLE_B_START: hole_b_start_ff <= csr_data;
               REG_HOLE_B_END:   hole_b_end_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (ctrl_cmd.accept) begin
         cmd_ff  <= command_type'(req_command);
         page_ff <= req_page;
      end
      if (rsp_load) begin
         rsp_page_out_ff   <= res_page;
         rsp_status_ff     <= res_status;
         rsp_free_count_ff <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page_out   = rsp_page_out_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = rsp_free_count_ff;

   // free count never exceeds the page count
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_PAGES))
      else $error("free count above page count");

   // a successful allocation removes exactly one page
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.exec_en && cmd_ff == CMD_ALLOC && count_ff != '0)
      |=> (count_ff == $past(count_ff) - 1'b1) && (rsp_status_ff == ST_OK))
      else $error("allocation did not take one page");

   // an allocation from an empty list reports no page
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.exec_en && cmd_ff == CMD_ALLOC && count_ff == '0)
      |=> (rsp_status_ff == ST_NO_FREE) && (rsp_page_out_ff == '0) && (count_ff == '0))
      else $error("empty allocation changed the list");

endmodule

FILE: hdl/page_frame_free_list_allocator.sv
// Page frame allocator keeping free pages in a linked LIFO list held in a link RAM, with a
// 2-bit state per page in a state RAM. After reset the block sweeps the state RAM to mark
// every page free, one page per cycle, with req_ready low; configuration writes are taken
// during that time. A build (command 0) classifies and pushes one page per cycle, then
// answers, leaving the highest free page at the head. Allocate and free each do one
// registered RAM read (link of the head, or state of the page), then the head, count and
// RAM update. Unused command 3 answers with status ok. A result register sits on the
// response side, so a new word is accepted while the last result still waits to be taken;
// a command finishes only once that register is free.
module page_frame_free_list_allocator import pffa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [PAGE_W-1:0]    req_page,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PAGE_W-1:0]    rsp_page_out,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_free_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data
);

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   pffa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .dp_stat     (dp_stat),
      .ctrl_cmd    (ctrl_cmd)
   );

   // list state, memories and result register
   pffa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl_cmd       (ctrl_cmd),
      .dp_stat        (dp_stat),
      .req_command    (req_command),
      .req_page       (req_page),
      .csr_write      (csr_valid & csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_page_out   (rsp_page_out),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count)
   );

endmodule

FILE: test/tb_page_frame_free_list_allocator.sv
`timescale 1ns / 1ps

module tb_page_frame_free_list_allocator;
   import pffa_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_WORDS   = 200;

   typedef struct packed {
      logic [PAGE_W-1:0]  page_out;
      status_type         status;
      logic [COUNT_W-1:0] free_count;
   } page_reply_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command    = CMD_NONE;
   logic [PAGE_W-1:0]    req_page       = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [PAGE_W-1:0]    rsp_page_out;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_free_count;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = REG_TOTAL_PAGES;
   logic [REG_W-1:0]     csr_data       = '0;

   // allocator state as the testbench sees it
   page_state_type       frame_state [MAX_PAGES];
   logic [PAGE_W-1:0]    frame_link  [MAX_PAGES];
   logic [PAGE_W-1:0]    list_top;
   logic [COUNT_W-1:0]   frames_free;
   logic [REG_W-1:0]     total_pages_cfg;
   logic [REG_W-1:0]     system_pages_cfg;
   logic [REG_W-1:0]     hole_a_start_cfg;
   logic [REG_W-1:0]     hole_a_end_cfg;
   logic [REG_W-1:0]     hole_b_start_cfg;
   logic [REG_W-1:0]     hole_b_end_cfg;

   page_reply_type       owed_replies [$];
   logic [PAGE_W-1:0]    held_pages [$];
   page_reply_type       last_reply;

   int unsigned          send_idle_pct = 21;
   int unsigned          recv_idle_pct = 79;
   logic                 hold_start    = 1'b0;
   int unsigned          hold_left     = 0;
   int unsigned          cycle_count   = 0;
   int unsigned          error_count   = 0;

   page_frame_free_list_allocator u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_page       (req_page),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_page_out   (rsp_page_out),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // long receiver hold-off, counted down here
   always @(negedge clock) begin
      if (hold_start)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // receiver ready with random stalls
   always @(negedge clock) begin
      if (hold_start || hold_left != 0)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each returned word with the oldest owed reply
   always @(posedge clock) begin : reply_check
      page_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_replies.size() == 0) begin
            $error("unexpected response word: page_out %0d status %0d free_count %0d",
                   rsp_page_out, rsp_status, rsp_free_count);
            error_count = error_count + 1;
         end else begin
            want = owed_replies.pop_front();
            if (rsp_page_out !== want.page_out) begin
               $error("page_out mismatch: expected %0d, actual %0d", want.page_out, rsp_page_out);
               error_count = error_count + 1;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count = error_count + 1;
            end
            if (rsp_free_count !== want.free_count) begin
               $error("free_count mismatch: expected %0d, actual %0d",
                      want.free_count, rsp_free_count);
               error_count = error_count + 1;
            end
         end
      end
   end

   function automatic int unsigned frame_limit();
      return (total_pages_cfg < MAX_PAGES) ? int'(total_pages_cfg) : MAX_PAGES;
   endfunction

   function automatic void push_frame(int unsigned p);
      frame_link[p]  = list_top;
      list_top       = PAGE_W'(p);
      frame_state[p] = PS_FREE;
      frames_free    = frames_free + 1'b1;
   endfunction

   // classify every page, push the free ones in ascending order
   function automatic void rebuild_list();
      int unsigned lim;
      lim         = frame_limit();
      list_top    = '0;
      frames_free = '0;
      for (int unsigned p = 0; p < MAX_PAGES; p++) begin
         if (p >= lim || (p >= hole_a_start_cfg && p < hole_a_end_cfg) ||
             (p >= hole_b_start_cfg && p < hole_b_end_cfg))
            frame_state[p] = PS_BAD;
         else if (p < system_pages_cfg)
            frame_state[p] = PS_SYS;
         else
            push_frame(p);
      end
   endfunction

   // reply to one command and update the free list
   function automatic page_reply_type apply_page_command(command_type cmd,
                                                         logic [PAGE_W-1:0] pg);
      page_reply_type    r;
      logic [PAGE_W-1:0] top;
      r.page_out = '0;
      r.status   = ST_OK;
      case (cmd)
         CMD_BUILD: begin
            rebuild_list();
         end
         CMD_ALLOC: begin
            if (frames_free == 0) begin
               r.status = ST_NO_FREE;
            end else begin
               top              = list_top;
               r.page_out       = top;
               list_top         = frame_link[top];
               frame_state[top] = PS_ALLOC;
               frame_link[top]  = '0;
               frames_free      = frames_free - 1'b1;
            end
         end
         CMD_FREE: begin
            if (pg >= frame_limit())
               r.status = ST_RANGE;
            else if (frame_state[pg] == PS_FREE || frame_state[pg] == PS_BAD)
               r.status = ST_NOT_FREEABLE;
            else
               push_frame(pg);
         end
         default: begin
         end
      endcase
      r.free_count = frames_free;
      return r;
   endfunction

   // offer one request word, record the owed reply once it is taken
   task automatic send_command(input command_type cmd, input logic [PAGE_W-1:0] pg);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_page    <= pg;
      do @(posedge clock); while (!req_ready);
      last_reply = apply_page_command(cmd, pg);
      owed_replies.push_back(last_reply);
   endtask

   // stop offering and wait for every owed reply
   task automatic drain_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= REG_W'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_TOTAL_PAGES:  total_pages_cfg  = REG_W'(value);
         REG_SYSTEM_PAGES: system_pages_cfg = REG_W'(value);
         REG_HOLE_A_START: hole_a_start_cfg = REG_W'(value);
         REG_HOLE_A_END:   hole_a_end_cfg   = REG_W'(value);
         REG_HOLE_B_START: hole_b_start_cfg = REG_W'(value);
         REG_HOLE_B_END:   hole_b_end_cfg   = REG_W'(value);
         default: begin
         end
      endcase
   endtask

   task automatic load_config(input int unsigned total, input int unsigned sys,
                              input int unsigned a_lo, input int unsigned a_hi,
                              input int unsigned b_lo, input int unsigned b_hi);
      write_register(REG_TOTAL_PAGES, total);
      write_register(REG_SYSTEM_PAGES, sys);
      write_register(REG_HOLE_A_START, a_lo);
      write_register(REG_HOLE_A_END, a_hi);
      write_register(REG_HOLE_B_START, b_lo);
      write_register(REG_HOLE_B_END, b_hi);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic build_list();
      send_command(CMD_BUILD, PAGE_W'($urandom));
      held_pages.delete();
   endtask

   // either release a page we hold or take a new one
   task automatic churn_held_page(input int unsigned release_pct);
      int unsigned       pick;
      logic [PAGE_W-1:0] pg;
      if (held_pages.size() != 0 && $urandom_range(99) < release_pct) begin
         pick = $urandom_range(held_pages.size() - 1);
         pg   = held_pages[pick];
         held_pages.delete(pick);
         send_command(CMD_FREE, pg);
      end else begin
         send_command(CMD_ALLOC, PAGE_W'($urandom));
         if (last_reply.status == ST_OK)
            held_pages.push_back(last_reply.page_out);
      end
   endtask

   // random register settings, mostly small page counts
   task automatic load_random_config();
      int unsigned total;
      int unsigned sys;
      int unsigned a_lo;
      int unsigned a_hi;
      int unsigned b_lo;
      int unsigned b_hi;
      case ($urandom_range(9)) inside
         0:       total = 4096;
         1:       total = 1;
         2, 3:    total = $urandom_range(1, 4096);
         default: total = $urandom_range(1, 48);
      endcase
      if ($urandom_range(3) == 0)
         sys = $urandom_range(0, 4096);
      else
         sys = $urandom_range(0, total / 4);
      a_lo = $urandom_range(0, total);
      a_hi = a_lo + $urandom_range(0, 5);
      if (a_hi > 4096)
         a_hi = 4096;
      b_lo = $urandom_range(0, total);
      if ($urandom_range(4) == 0)
         b_hi = $urandom_range(0, 4096);
      else
         b_hi = (b_lo + 3 > 4096) ? 4096 : b_lo + 3;
      load_config(total, sys, a_lo, a_hi, b_lo, b_hi);
   endtask

   // list empty and every page free before the first build
   task automatic test_before_build();
      send_command(CMD_FREE, 12'd5);
      send_command(CMD_ALLOC, 12'd0);
      send_command(CMD_FREE, 12'd4095);
      drain_replies();
   endtask

   // small layout with system pages and two holes, run dry and refill
   task automatic test_small_layout();
      load_config(12, 3, 5, 7, 9, 10);
      build_list();
      repeat (6) send_command(CMD_ALLOC, 12'd0);
      send_command(CMD_ALLOC, 12'hfff);
      send_command(CMD_FREE, 12'd0);
      send_command(CMD_FREE, 12'd11);
      send_command(CMD_FREE, 12'd11);
      send_command(CMD_FREE, 12'd5);
      send_command(CMD_FREE, 12'd12);
      send_command(CMD_FREE, 12'd4095);
      send_command(CMD_NONE, 12'hfff);
      send_command(CMD_ALLOC, 12'd0);
      drain_replies();
   endtask

   // one page, all system, all bad, all free
   task automatic test_extreme_layouts();
      load_config(1, 0, 0, 0, 0, 0);
      build_list();
      send_command(CMD_ALLOC, 12'd0);
      send_command(CMD_ALLOC, 12'd0);
      send_command(CMD_FREE, 12'd0);
      drain_replies();
      load_config(4096, 4096, 0, 0, 4096, 0);
      build_list();
      send_command(CMD_FREE, 12'd4095);
      send_command(CMD_ALLOC, 12'd0);
      drain_replies();
      load_config(4096, 0, 0, 4096, 0, 0);
      build_list();
      send_command(CMD_FREE, 12'd100);
      drain_replies();
      load_config(4096, 0, 0, 0, 0, 0);
      build_list();
      send_command(CMD_ALLOC, 12'd0);
      drain_replies();
   endtask

   // random layouts, mostly alloc and free of held pages plus some noise
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned words);
      int unsigned sent;
      int unsigned pick;
      int unsigned top_page;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < words) begin
         drain_replies();
         load_random_config();
         build_list();
         sent++;
         repeat ($urandom_range(25, 60)) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
               build_list();
            end else if (pick < 6) begin
               send_command(CMD_NONE, PAGE_W'($urandom));
            end else if (pick < 14) begin
               send_command(CMD_FREE, PAGE_W'($urandom));
            end else if (pick < 22) begin
               top_page = (frame_limit() + 1 > 4095) ? 4095 : frame_limit() + 1;
               send_command(CMD_FREE, PAGE_W'($urandom_range(0, top_page)));
            end else begin
               churn_held_page(45);
            end
            sent++;
         end
      end
      drain_replies();
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_config(64, 2, 10, 12, 40, 41);
      build_list();
      drain_replies();
      @(negedge clock);
      hold_start <= 1'b1;
      @(negedge clock);
      hold_start <= 1'b0;
      repeat (24) churn_held_page(40);
      drain_replies();
   endtask

   initial begin
      foreach (frame_state[i]) begin
         frame_state[i] = PS_FREE;
         frame_link[i]  = '0;
      end
      list_top         = '0;
      frames_free      = '0;
      total_pages_cfg  = 13'd4096;
      system_pages_cfg = '0;
      hole_a_start_cfg = '0;
      hole_a_end_cfg   = '0;
      hole_b_start_cfg = '0;
      hole_b_end_cfg   = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_build();
      test_small_layout();
      test_extreme_layouts();
      test_random_traffic(21, 79, PHASE_WORDS);
      test_random_traffic(79, 21, PHASE_WORDS);
      test_random_traffic(0, 0, PHASE_WORDS);
      test_backpressure();

      drain_replies();
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
